### rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    // Pipeline depth and the register stage that each part of the work lands in
    localparam int PIPE_DEPTH = 8;
    localparam int ST_FRAC    = 0;  // bytes to fractions
    localparam int ST_PROD    = 1;  // lightness * saturation, hue positions
    localparam int ST_T1      = 2;  // first temporary
    localparam int ST_T2      = 3;  // second temporary
    localparam int ST_SEL     = 4;  // span, region and ramp factor per channel
    localparam int ST_MUL     = 5;  // span * factor
    localparam int ST_SUM     = 6;  // channel fraction
    localparam int ST_OUT     = 7;  // channel bytes, output register

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } hsl_pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] advance;
    } pipe_ctrl_t;

    typedef enum logic [1:0] {
        REGION_RISE,
        REGION_TOP,
        REGION_FALL,
        REGION_BOTTOM
    } region_t;

endpackage

### rtl/hsl_to_rgb_converter_core.sv
// An accepted request goes through stages ST_FRAC to ST_OUT in order to reach m_data.
// Throughput: one pixel per cycle; every stage holds on a stall and fills bubbles,
// so the input keeps taking requests while any stage ahead is empty.
// The rate is set by the eight-stage pipeline, one register stage per arithmetic step.
// Reset (aresetn low, synchronous) clears the stage valid bits only; data registers keep.
module hsl_to_rgb_converter_core
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  hsl_pixel_t s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rgb_pixel_t m_data
);

    logic [PIPE_DEPTH-1:0] valid_reg, valid_in, advance;
    pipe_ctrl_t            ctrl;

    // Each stage moves when empty or when the stage after it moves
    always_comb begin
        advance[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            advance[i] = !valid_reg[i] || advance[i+1];
        end
    end

    assign ctrl.advance = advance;
    assign valid_in     = {valid_reg[PIPE_DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                if (advance[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    // Gray bypass for zero saturation travels alongside the arithmetic
    logic [PIPE_DEPTH-2:0] zero_reg;
    logic [7:0]            light_reg [PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (advance[0]) begin
            zero_reg[0]  <= (s_data.saturation == 8'h00);
            light_reg[0] <= s_data.lightness;
        end
        for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
            if (advance[i]) begin
                zero_reg[i]  <= zero_reg[i-1];
                light_reg[i] <= light_reg[i-1];
            end
        end
    end

    logic [FRACTION_BITS:0]   t1, t2;
    logic [FRACTION_BITS-1:0] pos_r, pos_g, pos_b;
    logic [7:0]               level_r, level_g, level_b;

    hsl2rgb_temp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_temp (
        .aclk (aclk),
        .ctrl (ctrl),
        .pix  (s_data),
        .t1   (t1),
        .t2   (t2),
        .pos_r(pos_r),
        .pos_g(pos_g),
        .pos_b(pos_b)
    );

    hsl2rgb_channel #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_chan_r (
        .aclk (aclk),
        .ctrl (ctrl),
        .t1   (t1),
        .t2   (t2),
        .pos  (pos_r),
        .level(level_r)
    );

    hsl2rgb_channel #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_chan_g (
        .aclk (aclk),
        .ctrl (ctrl),
        .t1   (t1),
        .t2   (t2),
        .pos  (pos_g),
        .level(level_g)
    );

    hsl2rgb_channel #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_chan_b (
        .aclk (aclk),
        .ctrl (ctrl),
        .t1   (t1),
        .t2   (t2),
        .pos  (pos_b),
        .level(level_b)
    );

    rgb_pixel_t m_data_next, m_data_reg;

    always_comb begin
        if (zero_reg[ST_SUM]) begin
            m_data_next.red   = light_reg[ST_SUM];
            m_data_next.green = light_reg[ST_SUM];
            m_data_next.blue  = light_reg[ST_SUM];
        end else begin
            m_data_next.red   = level_r;
            m_data_next.green = level_g;
            m_data_next.blue  = level_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance[ST_OUT]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = valid_reg[ST_OUT];
    assign s_ready = advance[ST_FRAC];

    // An empty or draining output stage must never block the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output stage drains");

    // An accepted request occupies the first stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[ST_FRAC])
        else $error("accepted request lost at first stage");

    // A valid ST_SUM stage that cannot move keeps the output stage full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_SUM] && !advance[ST_SUM]) |-> valid_reg[ST_OUT])
        else $error("stage held with an empty stage ahead");

    // Reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

### rtl/hsl2rgb_temp.sv
module hsl2rgb_temp
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     aclk,
    input  pipe_ctrl_t               ctrl,
    input  hsl_pixel_t               pix,
    output logic [FRACTION_BITS:0]   t1,
    output logic [FRACTION_BITS:0]   t2,
    output logic [FRACTION_BITS-1:0] pos_r,
    output logic [FRACTION_BITS-1:0] pos_g,
    output logic [FRACTION_BITS-1:0] pos_b
);

    localparam int FW = FRACTION_BITS + 1;
    localparam int unsigned ONE_I   = 32'd1 << FRACTION_BITS;
    localparam int unsigned THIRD_I = ONE_I / 3;
    localparam logic [FW-1:0]            ONE   = FW'(ONE_I);
    localparam logic [FW-1:0]            HALF  = FW'(ONE_I >> 1);
    localparam logic [FRACTION_BITS-1:0] THIRD = FRACTION_BITS'(THIRD_I);

    // ceil(v * ONE / 255): v / 255 is the byte v repeated in binary, so the
    // floor is the leading fraction bits of that pattern; only 0 and 255 are exact
    function automatic logic [FW-1:0] to_frac(input logic [7:0] v);
        logic [31:0]   rep;
        logic [FW-1:0] frac;
        rep = {v, v, v, v};
        if (v == 8'hFF) begin
            frac = ONE;
        end else if (v == 8'h00) begin
            frac = '0;
        end else begin
            frac = {1'b0, rep[31 -: FRACTION_BITS]} + FW'(1);
        end
        return frac;
    endfunction

    // Fractions
    logic [FW-1:0] hf_reg, sf_reg, lf_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.advance[ST_FRAC]) begin
            hf_reg <= to_frac(pix.hue);
            sf_reg <= to_frac(pix.saturation);
            lf_reg <= to_frac(pix.lightness);
        end
    end

    // Product and hue positions
    logic [2*FW-1:0]          ls_prod;
    logic [FW-1:0]            ls_next;
    logic [FRACTION_BITS-1:0] pr_next, pb_next;
    logic [FW-1:0]            ls_reg, lf2_reg, sf2_reg;
    logic [FRACTION_BITS-1:0] pr2_reg, pg2_reg, pb2_reg;

    assign ls_prod = {{FW{1'b0}}, lf_reg} * {{FW{1'b0}}, sf_reg};
    assign ls_next = ls_prod[FRACTION_BITS +: FW];
    assign pr_next = hf_reg[FRACTION_BITS-1:0] + THIRD;
    assign pb_next = hf_reg[FRACTION_BITS-1:0] - THIRD;

    always_ff @(posedge aclk) begin
        if (ctrl.advance[ST_PROD]) begin
            ls_reg  <= ls_next;
            lf2_reg <= lf_reg;
            sf2_reg <= sf_reg;
            pr2_reg <= pr_next;
            pg2_reg <= hf_reg[FRACTION_BITS-1:0];
            pb2_reg <= pb_next;
        end
    end

    // First temporary
    logic [FW:0]              t1_sum;
    logic [FW-1:0]            t1_next;
    logic [FW-1:0]            t1_reg, lf3_reg;
    logic [FRACTION_BITS-1:0] pr3_reg, pg3_reg, pb3_reg;

    always_comb begin
        if (lf2_reg < HALF) begin
            t1_sum = {1'b0, lf2_reg} + {1'b0, ls_reg};
        end else begin
            t1_sum = {1'b0, lf2_reg} + {1'b0, sf2_reg} - {1'b0, ls_reg};
        end
        t1_next = (t1_sum > {1'b0, ONE}) ? ONE : t1_sum[FW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance[ST_T1]) begin
            t1_reg  <= t1_next;
            lf3_reg <= lf2_reg;
            pr3_reg <= pr2_reg;
            pg3_reg <= pg2_reg;
            pb3_reg <= pb2_reg;
        end
    end

    // Second temporary, clamped to 0..ONE
    logic [FW:0]              lf_dbl, t2_diff;
    logic [FW-1:0]            t2_next;
    logic [FW-1:0]            t1o_reg, t2_reg;
    logic [FRACTION_BITS-1:0] pr4_reg, pg4_reg, pb4_reg;

    always_comb begin
        lf_dbl  = {lf3_reg, 1'b0};
        t2_diff = lf_dbl - {1'b0, t1_reg};
        if ({1'b0, t1_reg} > lf_dbl) begin
            t2_next = '0;
        end else if (t2_diff > {1'b0, ONE}) begin
            t2_next = ONE;
        end else begin
            t2_next = t2_diff[FW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance[ST_T2]) begin
            t1o_reg <= t1_reg;
            t2_reg  <= t2_next;
            pr4_reg <= pr3_reg;
            pg4_reg <= pg3_reg;
            pb4_reg <= pb3_reg;
        end
    end

    assign t1    = t1o_reg;
    assign t2    = t2_reg;
    assign pos_r = pr4_reg;
    assign pos_g = pg4_reg;
    assign pos_b = pb4_reg;

endmodule

### rtl/hsl2rgb_channel.sv
module hsl2rgb_channel
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     aclk,
    input  pipe_ctrl_t               ctrl,
    input  logic [FRACTION_BITS:0]   t1,
    input  logic [FRACTION_BITS:0]   t2,
    input  logic [FRACTION_BITS-1:0] pos,
    output logic [7:0]               level
);

    localparam int FW = FRACTION_BITS + 1;
    localparam int unsigned ONE_I        = 32'd1 << FRACTION_BITS;
    localparam int unsigned TWO_THIRDS_I = (2 * ONE_I) / 3;
    localparam logic [FRACTION_BITS-1:0] TWO_THIRDS = FRACTION_BITS'(TWO_THIRDS_I);
    localparam logic [FRACTION_BITS+2:0] ONE_X6     = (FRACTION_BITS + 3)'(ONE_I);
    localparam logic [FRACTION_BITS+1:0] TWO_X3     = (FRACTION_BITS + 2)'(2 * ONE_I);

    // Region, ramp factor and span
    logic [FRACTION_BITS+2:0] six_pos, six_rest;
    logic [FRACTION_BITS+1:0] three_pos;
    logic [FRACTION_BITS-1:0] rest;
    logic [FW-1:0]            span_next, factor_next;
    region_t                  region_next;
    logic [FW-1:0]            span_reg, factor_reg, t1s_reg, t2s_reg;
    region_t                  region_s_reg;

    always_comb begin
        six_pos   = {3'b000, pos} * (FRACTION_BITS + 3)'(6);
        three_pos = {2'b00, pos} * (FRACTION_BITS + 2)'(3);
        rest      = (TWO_THIRDS >= pos) ? (TWO_THIRDS - pos) : '0;
        six_rest  = {3'b000, rest} * (FRACTION_BITS + 3)'(6);
        span_next = (t1 >= t2) ? (t1 - t2) : '0;
        if (six_pos < ONE_X6) begin
            region_next = REGION_RISE;
        end else if (!pos[FRACTION_BITS-1]) begin
            region_next = REGION_TOP;
        end else if (three_pos < TWO_X3) begin
            region_next = REGION_FALL;
        end else begin
            region_next = REGION_BOTTOM;
        end
        // Both ramps stay within 0..ONE inside their regions
        factor_next = (region_next == REGION_RISE) ? six_pos[FW-1:0] : six_rest[FW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance[ST_SEL]) begin
            span_reg     <= span_next;
            factor_reg   <= factor_next;
            region_s_reg <= region_next;
            t1s_reg      <= t1;
            t2s_reg      <= t2;
        end
    end

    // Ramp product, truncated
    logic [2*FW-1:0]          ramp_prod;
    logic [FRACTION_BITS+1:0] prod_reg;
    logic [FW-1:0]            t1m_reg, t2m_reg;
    region_t                  region_m_reg;

    assign ramp_prod = {{FW{1'b0}}, span_reg} * {{FW{1'b0}}, factor_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.advance[ST_MUL]) begin
            prod_reg     <= ramp_prod[2*FW-1:FRACTION_BITS];
            region_m_reg <= region_s_reg;
            t1m_reg      <= t1s_reg;
            t2m_reg      <= t2s_reg;
        end
    end

    // Channel fraction
    logic [FRACTION_BITS+2:0] c_next, c_reg;

    always_comb begin
        case (region_m_reg) inside
            REGION_RISE, REGION_FALL: c_next = {2'b00, t2m_reg} + {1'b0, prod_reg};
            REGION_TOP:               c_next = {2'b00, t1m_reg};
            default:                  c_next = {2'b00, t2m_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance[ST_SUM]) begin
            c_reg <= c_next;
        end
    end

    // c * 255 / ONE, saturated at 255
    logic [FRACTION_BITS+10:0] scaled;
    logic [10:0]               scaled_hi;

    assign scaled    = {c_reg, 8'h00} - {8'h00, c_reg};
    assign scaled_hi = scaled[FRACTION_BITS+10:FRACTION_BITS];
    assign level     = (scaled_hi > 11'd255) ? 8'hFF : scaled_hi[7:0];

endmodule
